// ===== rtl/clcd_pkg.sv =====
// shared types, constants and lookup functions for the character lcd controller
package clcd_pkg;

    localparam int MAX_COLUMNS_DEF = 20;
    localparam int MAX_ROWS_DEF    = 4;

    localparam int PW = 7;
    localparam int SW = 8;
    localparam int IW = 6;

    localparam logic [2:0] MODE_SETPOS  = 3'd0;
    localparam logic [2:0] MODE_CHAR    = 3'd1;
    localparam logic [2:0] MODE_CLEAR   = 3'd2;
    localparam logic [2:0] MODE_REFRESH = 3'd3;
    localparam logic [2:0] MODE_GLYPH   = 3'd4;
    localparam logic [2:0] MODE_INIT    = 3'd5;

    localparam logic [1:0] REG_COL_COUNT = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT = 2'd1;
    localparam logic [1:0] REG_BUS_8BIT  = 2'd2;

    localparam logic [4:0] COL_COUNT_RST = 5'd20;
    localparam logic [2:0] ROW_COUNT_RST = 3'd4;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_SET_CGRAM = 8'h40;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POSUPD,
        ST_NEWLINE,
        ST_FETCH,
        ST_LOAD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SRC_REFRESH,
        SRC_GLYPH,
        SRC_INIT
    } src_t;

    typedef struct packed {
        logic [4:0]    cols;
        logic [2:0]    rows;
        logic [SW-1:0] size;
        logic          bus8;
    } cfg_t;

    typedef struct packed {
        logic [SW-1:0] sum;
        logic [SW-1:0] sat;
        logic          le;
    } alu_res_t;

    function automatic logic [7:0] row_offset(input logic [1:0] r);
        logic [7:0] v;
        case (r)
            2'd0:    v = 8'h00;
            2'd1:    v = 8'h40;
            2'd2:    v = 8'h14;
            default: v = 8'h54;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] init_byte(input logic [2:0] k, input logic bus8);
        logic [7:0] v;
        case (k)
            3'd0:    v = 8'h03;
            3'd1:    v = 8'h03;
            3'd2:    v = 8'h03;
            3'd3:    v = 8'h02;
            3'd4:    v = bus8 ? 8'h38 : 8'h28;
            3'd5:    v = 8'h0C;
            3'd6:    v = 8'h01;
            default: v = 8'h06;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/character_lcd_text_buffer_controller.sv =====
// top level: apb register file, character store and item sequencer
//
// Items are taken with start while busy is low; busy stays high until the
// last bus write of the item has been shown. Set position, tab and plain
// characters pass through the position update state; newline/return steps
// row by row in the newline state. Refresh (cols+1 bytes), glyph (9) and
// init (8) emit their bytes one at a time through fetch, load and emit
// states, in nibble mode as two writes each, high nibble first; refresh
// steps its read address through the single shared adder and reads a
// store with one write and one read port and registered read. Each bus write
// appears for exactly one cycle with result_valid high and must be captured
// then; the receiver cannot stall. Clear and init take effect at once
// through per-entry valid bits, so there is no clearing pass after reset.
module character_lcd_text_buffer_controller
    import clcd_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [4:0]  column,
    input  logic [1:0]  row,
    input  logic [7:0]  character,
    input  logic [2:0]  glyph_slot,
    input  logic [63:0] glyph_rows,
    output logic        result_valid,
    output logic        register_select,
    output logic [7:0]  bus_value,
    output logic        last
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [4:0]    col_count_reg;
    logic [2:0]    row_count_reg;
    logic          bus_8bit_reg;
    logic [4:0]    eff_cols;
    logic [2:0]    eff_rows;
    cfg_t          cfg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= COL_COUNT_RST;
            row_count_reg <= ROW_COUNT_RST;
            bus_8bit_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_COL_COUNT: col_count_reg <= pwdata[4:0];
                REG_ROW_COUNT: row_count_reg <= pwdata[2:0];
                REG_BUS_8BIT:  bus_8bit_reg  <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COL_COUNT: prdata = {27'b0, col_count_reg};
            REG_ROW_COUNT: prdata = {29'b0, row_count_reg};
            REG_BUS_8BIT:  prdata = {31'b0, bus_8bit_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        if (col_count_reg == '0)
        begin
            eff_cols = 5'd1;
        end
        else if (col_count_reg > 5'(MAX_COLUMNS))
        begin
            eff_cols = 5'(MAX_COLUMNS);
        end
        else
        begin
            eff_cols = col_count_reg;
        end

        if (row_count_reg == '0)
        begin
            eff_rows = 3'd1;
        end
        else if (row_count_reg > 3'(MAX_ROWS))
        begin
            eff_rows = 3'(MAX_ROWS);
        end
        else
        begin
            eff_rows = row_count_reg;
        end
    end

    assign cfg.cols = eff_cols;
    assign cfg.rows = eff_rows;
    assign cfg.size = SW'(eff_cols) * SW'(eff_rows);
    assign cfg.bus8 = bus_8bit_reg;

    clcd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    clcd_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .mode            (mode),
        .column          (column),
        .row             (row),
        .character       (character),
        .glyph_slot      (glyph_slot),
        .glyph_rows      (glyph_rows),
        .cfg             (cfg),
        .busy            (busy),
        .result_valid    (result_valid),
        .register_select (register_select),
        .bus_value       (bus_value),
        .last            (last),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata)
    );

endmodule

// ===== rtl/clcd_ram.sv =====
// generic single-port-write ram with registered read
module clcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/clcd_alu.sv =====
// shared adder with saturation and compare against the text position
module clcd_alu
    import clcd_pkg::*;
(
    input  logic [SW-1:0] a,
    input  logic [SW-1:0] b,
    input  logic [SW-1:0] size,
    input  logic [PW-1:0] pos,
    output alu_res_t      res
);

    logic [SW-1:0] sum;

    assign sum     = a + b;
    assign res.sum = sum;
    assign res.sat = (sum > size) ? size : sum;
    assign res.le  = (sum <= SW'(pos));

endmodule

// ===== rtl/clcd_seq.sv =====
// item sequencer: position updates, store writes and bus write emission
module clcd_seq
    import clcd_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic [2:0]                                mode,
    input  logic [4:0]                                column,
    input  logic [1:0]                                row,
    input  logic [7:0]                                character,
    input  logic [2:0]                                glyph_slot,
    input  logic [63:0]                               glyph_rows,
    input  cfg_t                                      cfg,
    output logic                                      busy,
    output logic                                      result_valid,
    output logic                                      register_select,
    output logic [7:0]                                bus_value,
    output logic                                      last,
    output logic                                      ram_we,
    output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]   ram_waddr,
    output logic [7:0]                                ram_wdata,
    output logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]   ram_raddr,
    input  logic [7:0]                                ram_rdata
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    state_t         state_reg, state_next;
    src_t           src_reg, src_next;
    logic [PW-1:0]  pos_reg, pos_next;
    logic [SW-1:0]  a_reg, a_next;
    logic [SW-1:0]  b_reg, b_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [IW-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]  addr_reg, addr_next;
    logic [7:0]     byte_reg, byte_next;
    logic [7:0]     cmd_reg, cmd_next;
    logic           rs_reg, rs_next;
    logic           phase_reg, phase_next;
    logic [63:0]    glyph_reg, glyph_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic           rd_ok_reg;

    logic [SW-1:0]  alu_a, alu_b;
    alu_res_t       alu_res;
    logic [SW-1:0]  row_base;
    logic           byte_done;
    logic           final_byte;

    clcd_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .size (cfg.size),
        .pos  (pos_reg),
        .res  (alu_res)
    );

    assign row_base   = SW'(cfg.cols) * SW'(row);
    assign byte_done  = cfg.bus8 || phase_reg;
    assign final_byte = (idx_reg == cnt_reg - IW'(1));
    assign busy       = (state_reg != ST_IDLE);
    assign ram_raddr  = addr_reg;
    assign ram_waddr  = pos_reg[AW-1:0];
    assign ram_wdata  = character;

    always_comb
    begin
        alu_a = a_reg;
        alu_b = b_reg;
        if (state_reg == ST_NEWLINE)
        begin
            alu_b = SW'(cfg.cols);
        end
        else if (state_reg == ST_EMIT)
        begin
            alu_a = SW'(addr_reg);
            alu_b = SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            valid_reg <= '0;
            phase_reg <= 1'b0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        addr_reg  <= addr_next;
        byte_reg  <= byte_next;
        cmd_reg   <= cmd_next;
        rs_reg    <= rs_next;
        glyph_reg <= glyph_next;
        rd_ok_reg <= valid_reg[addr_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        src_next        = src_reg;
        pos_next        = pos_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        byte_next       = byte_reg;
        cmd_next        = cmd_reg;
        rs_next         = rs_reg;
        phase_next      = phase_reg;
        glyph_next      = glyph_reg;
        valid_next      = valid_reg;
        ram_we          = 1'b0;
        result_valid    = 1'b0;
        register_select = rs_reg;
        bus_value       = cfg.bus8 ? byte_reg
                        : (phase_reg ? {4'b0, byte_reg[3:0]} : {4'b0, byte_reg[7:4]});
        last            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    unique case (mode)
                        MODE_SETPOS:
                        begin
                            a_next     = SW'(column);
                            b_next     = row_base;
                            state_next = ST_POSUPD;
                        end
                        MODE_CHAR:
                        begin
                            if (SW'(pos_reg) < cfg.size)
                            begin
                                if (character == CH_LF || character == CH_CR)
                                begin
                                    a_next     = '0;
                                    state_next = ST_NEWLINE;
                                end
                                else if (character == CH_TAB)
                                begin
                                    a_next     = SW'(pos_reg);
                                    b_next     = SW'(4);
                                    state_next = ST_POSUPD;
                                end
                                else
                                begin
                                    ram_we                      = 1'b1;
                                    valid_next[pos_reg[AW-1:0]] = 1'b1;
                                    a_next                      = SW'(pos_reg);
                                    b_next                      = SW'(1);
                                    state_next                  = ST_POSUPD;
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        MODE_REFRESH:
                        begin
                            if (3'(row) < cfg.rows)
                            begin
                                src_next   = SRC_REFRESH;
                                cmd_next   = CMD_SET_DDRAM | row_offset(row);
                                cnt_next   = IW'(cfg.cols) + IW'(1);
                                addr_next  = row_base[AW-1:0];
                                state_next = ST_FETCH;
                            end
                        end
                        MODE_GLYPH:
                        begin
                            src_next   = SRC_GLYPH;
                            cmd_next   = CMD_SET_CGRAM | {2'b0, glyph_slot, 3'b0};
                            glyph_next = glyph_rows;
                            cnt_next   = IW'(9);
                            state_next = ST_FETCH;
                        end
                        MODE_INIT:
                        begin
                            src_next   = SRC_INIT;
                            cnt_next   = IW'(8);
                            valid_next = '0;
                            state_next = ST_FETCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_POSUPD:
            begin
                pos_next   = alu_res.sat[PW-1:0];
                state_next = ST_IDLE;
            end
            ST_NEWLINE:
            begin
                if (alu_res.le)
                begin
                    a_next = alu_res.sum;
                end
                else
                begin
                    pos_next   = alu_res.sat[PW-1:0];
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                phase_next = 1'b0;
                case (src_reg)
                    SRC_REFRESH:
                    begin
                        if (idx_reg == '0)
                        begin
                            byte_next = cmd_reg;
                            rs_next   = 1'b0;
                        end
                        else
                        begin
                            byte_next = rd_ok_reg ? ram_rdata : CH_SPACE;
                            rs_next   = 1'b1;
                        end
                    end
                    SRC_GLYPH:
                    begin
                        if (idx_reg == '0)
                        begin
                            byte_next = cmd_reg;
                            rs_next   = 1'b0;
                        end
                        else
                        begin
                            byte_next  = glyph_reg[7:0];
                            glyph_next = glyph_reg >> 8;
                            rs_next    = 1'b1;
                        end
                    end
                    default:
                    begin
                        byte_next = init_byte(idx_reg[2:0], cfg.bus8);
                        rs_next   = 1'b0;
                    end
                endcase
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                result_valid = 1'b1;
                last         = byte_done && final_byte;
                if (!byte_done)
                begin
                    phase_next = 1'b1;
                end
                else if (final_byte)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                    if (src_reg == SRC_REFRESH && idx_reg != '0)
                    begin
                        addr_next = alu_res.sum[AW-1:0];
                    end
                    state_next = ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
